// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the lane edge and stopline detector.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/lsd_pkg.sv =====
// ----------------------------------------------------------------------------
// lsd_pkg
// Types and constants shared by the lane edge and stopline detector modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lsd_pkg;

   // Field widths.
   localparam int COL_W     = 10;
   localparam int ROW_W     = 10;
   localparam int VAL_W     = 8;
   localparam int ROAD_W    = 10;
   localparam int OFFSET_W  = 8;
   localparam int ERR_W     = 16;
   localparam int STOP_W    = 7;
   localparam int DIST_W    = 11;
   localparam int STABLE_W  = 3;

   // Numerator of the lateral error fits in 14 signed bits for any image width.
   localparam int NUM_W     = 14;
   localparam int FRAC_BITS = 11;
   localparam int MAG_W     = NUM_W - 1 + FRAC_BITS;
   localparam int ERR_MAX   = 2 ** (ERR_W - 1) - 1;

   // Port widths.
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 10;

   localparam int IMAGE_WIDTH_DEFAULT = 640;
   localparam int QUEUE_DEPTH         = 2;

   // Detection constants.
   localparam logic [VAL_W-1:0] HIT_LEVEL = 8'd120;
   localparam int STOP_COL_SPREAD = 50;
   localparam int STOP_SKEW_LIMIT = 15;
   localparam int STABLE_NEEDED   = 4;
   localparam int STOP_MIN        = 10;
   localparam int STOP_MAX        = 60;

   // Register reset values.
   localparam logic [ROW_W-1:0]    CONTROL_ROW_RESET = 10'd222;
   localparam logic [ROW_W-1:0]    STOP_ROW_RESET    = 10'd50;
   localparam logic [ROAD_W-1:0]   ROAD_WIDTH_RESET  = 10'd190;
   localparam logic [OFFSET_W-1:0] ROAD_OFFSET_RESET = 8'd30;

   localparam logic ACTION_PIXEL = 1'b0;
   localparam logic ACTION_EOF   = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CONTROL_ROW = 2'd0,
      CSR_STOP_ROW    = 2'd1,
      CSR_ROAD_WIDTH  = 2'd2,
      CSR_ROAD_OFFSET = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [ROW_W-1:0]    control_row;
      logic [ROW_W-1:0]    stop_row;
      logic [ROAD_W-1:0]   road_width;
      logic [OFFSET_W-1:0] road_offset;
   } cfg_type;

   // One end-of-frame job handed from the front to the back.
   typedef struct packed {
      logic                found;
      logic [NUM_W-1:0]    num;
      logic [ROAD_W-1:0]   divisor;
      logic [STOP_W-1:0]   stop_distance;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_FINISH
   } back_state_type;

endpackage

`default_nettype wire

// ===== design/lsd_queue.sv =====
// ----------------------------------------------------------------------------
// lsd_queue
// Short job queue between the pixel front and the division back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lsd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  lsd_pkg::job_type  push_data,
   input  logic              pop,
   output lsd_pkg::job_type  pop_data,
   output lsd_pkg::qstat_type qstat
);

   localparam int PTR_W = $clog2(lsd_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(lsd_pkg::QUEUE_DEPTH + 1);

   lsd_pkg::job_type entry_ff [lsd_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      qstat.full  = (count_ff == CNT_W'(lsd_pkg::QUEUE_DEPTH));
      qstat.empty = (count_ff == '0);
      pop_data    = entry_ff[rd_ptr_ff];
   end

   // Depth is a power of two, so the pointers wrap on their own.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/lsd_front.sv =====
// ----------------------------------------------------------------------------
// lsd_front
// Accepts pixel and end-of-frame words, tracks lane edges and stopline rows,
// and at end of frame builds a job with the error numerator and the
// debounced stopline distance.
// ----------------------------------------------------------------------------
`default_nettype none

module lsd_front #(
   parameter int IMAGE_WIDTH = lsd_pkg::IMAGE_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lsd_pkg::cfg_type            cfg,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic                        action,
   input  logic [lsd_pkg::COL_W-1:0]   pixel_col,
   input  logic [lsd_pkg::ROW_W-1:0]   pixel_row,
   input  logic [lsd_pkg::VAL_W-1:0]   pixel_value,
   input  logic                        in_left_lane,
   input  lsd_pkg::qstat_type          qstat,
   output logic                        push,
   output lsd_pkg::job_type            job
);

   localparam int COL_W  = lsd_pkg::COL_W;
   localparam int ROW_W  = lsd_pkg::ROW_W;
   localparam int NUM_W  = lsd_pkg::NUM_W;
   localparam int DIST_W = lsd_pkg::DIST_W;
   localparam int HALF   = IMAGE_WIDTH / 2;

   localparam logic [COL_W-1:0] HALF_COL   = COL_W'(HALF);
   localparam logic [COL_W-1:0] STOP_COL_L = COL_W'(HALF - lsd_pkg::STOP_COL_SPREAD);
   localparam logic [COL_W-1:0] STOP_COL_R = COL_W'(HALF + lsd_pkg::STOP_COL_SPREAD);
   localparam logic [COL_W:0]   WIDTH_LIM  = (COL_W + 1)'(IMAGE_WIDTH);
   localparam logic [NUM_W-1:0] WIDTH_NUM  = NUM_W'(IMAGE_WIDTH);

   localparam logic signed [DIST_W:0]   SKEW_LIM  = (DIST_W + 1)'(lsd_pkg::STOP_SKEW_LIMIT);
   localparam logic signed [DIST_W-1:0] DIST_MIN  = DIST_W'(lsd_pkg::STOP_MIN);
   localparam logic signed [DIST_W-1:0] DIST_MAX  = DIST_W'(lsd_pkg::STOP_MAX);
   localparam logic [lsd_pkg::STABLE_W-1:0] STABLE_FULL =
      lsd_pkg::STABLE_W'(lsd_pkg::STABLE_NEEDED);

   logic [COL_W-1:0] left_col_ff, left_col_in;
   logic [COL_W-1:0] right_col_ff, right_col_in;
   logic             right_valid_ff, right_valid_in;
   logic [ROW_W-1:0] left_stop_row_ff, left_stop_row_in;
   logic             left_stop_valid_ff, left_stop_valid_in;
   logic [ROW_W-1:0] right_stop_row_ff, right_stop_row_in;
   logic             right_stop_valid_ff, right_stop_valid_in;
   logic [lsd_pkg::STABLE_W-1:0] stable_ff, stable_in;
   logic signed [DIST_W-1:0]     held_ff, held_in;

   logic accept, pixel_hit, eof, on_control, in_stop_band;
   logic [lsd_pkg::ROAD_W-1:0] divisor;
   logic [COL_W:0]   left_pos, right_pos;
   logic [NUM_W-1:0] num_left, num_right, num_sel;
   logic left_ok, right_ok;
   logic signed [DIST_W-1:0] left_stop_dist, right_stop_dist, held_pick, held_next;
   logic signed [DIST_W:0]   skew;
   logic skew_ok;
   logic [lsd_pkg::STABLE_W-1:0] stable_next;

   // Pixels never wait on the back end; only an end-of-frame word needs queue room.
   assign in_ready = (action == lsd_pkg::ACTION_PIXEL) || !qstat.full;
   assign accept   = in_valid && in_ready;
   assign eof      = accept && (action == lsd_pkg::ACTION_EOF);

   always_comb begin
      pixel_hit    = accept && (action == lsd_pkg::ACTION_PIXEL) &&
                     ({1'b0, pixel_col} < WIDTH_LIM) && (pixel_value > lsd_pkg::HIT_LEVEL);
      on_control   = (pixel_row == cfg.control_row);
      in_stop_band = (pixel_row > cfg.stop_row) && (pixel_row <= cfg.control_row);
   end

   // End-of-frame arithmetic.
   always_comb begin
      divisor   = (cfg.road_width == '0) ? lsd_pkg::ROAD_W'(1) : cfg.road_width;
      left_pos  = {1'b0, left_col_ff} + (COL_W + 1)'(cfg.road_offset);
      right_pos = {1'b0, right_col_ff} + (COL_W + 1)'(cfg.road_offset);
      num_left  = (NUM_W'(left_pos) << 1) - WIDTH_NUM + (NUM_W'(divisor) << 1);
      num_right = (NUM_W'(right_pos) << 1) - WIDTH_NUM - (NUM_W'(divisor) << 1);
      left_ok   = (left_col_ff != '0);
      right_ok  = right_valid_ff;

      num_sel = '0;
      if (in_left_lane) begin
         priority if (left_ok) begin
            num_sel = num_left;
         end else if (right_ok) begin
            num_sel = num_right;
         end
      end else begin
         priority if (right_ok) begin
            num_sel = num_right;
         end else if (left_ok) begin
            num_sel = num_left;
         end
      end

      left_stop_dist  = left_stop_valid_ff ?
                        $signed({1'b0, cfg.control_row} - {1'b0, left_stop_row_ff}) : '0;
      right_stop_dist = right_stop_valid_ff ?
                        $signed({1'b0, cfg.control_row} - {1'b0, right_stop_row_ff}) : '0;
      skew       = $signed({left_stop_dist[DIST_W-1], left_stop_dist} -
                           {right_stop_dist[DIST_W-1], right_stop_dist});
      skew_ok    = (skew > -SKEW_LIM) && (skew < SKEW_LIM);

      stable_next = ((stable_ff < STABLE_FULL) && skew_ok) ? stable_ff + 1'b1 : '0;
      held_pick   = (stable_next >= STABLE_FULL) ? left_stop_dist : held_ff;
      held_next   = ((held_pick < DIST_MIN) || (held_pick > DIST_MAX)) ? '1 : held_pick;
   end

   always_comb begin
      push              = eof;
      job.found         = left_ok || right_ok;
      job.num           = num_sel;
      job.divisor       = divisor;
      job.stop_distance = lsd_pkg::STOP_W'(held_next);
   end

   // Tracker updates. End of frame clears the per-frame trackers.
   always_comb begin
      left_col_in         = left_col_ff;
      right_col_in        = right_col_ff;
      right_valid_in      = right_valid_ff;
      left_stop_row_in    = left_stop_row_ff;
      left_stop_valid_in  = left_stop_valid_ff;
      right_stop_row_in   = right_stop_row_ff;
      right_stop_valid_in = right_stop_valid_ff;
      stable_in           = stable_ff;
      held_in             = held_ff;
      if (eof) begin
         left_col_in         = '0;
         right_col_in        = '0;
         right_valid_in      = 1'b0;
         left_stop_row_in    = '0;
         left_stop_valid_in  = 1'b0;
         right_stop_row_in   = '0;
         right_stop_valid_in = 1'b0;
         stable_in           = stable_next;
         held_in             = held_next;
      end else if (pixel_hit) begin
         if (on_control) begin
            if ((pixel_col != '0) && (pixel_col <= HALF_COL) && (pixel_col > left_col_ff)) begin
               left_col_in = pixel_col;
            end
            if ((pixel_col >= HALF_COL) && (!right_valid_ff || (pixel_col < right_col_ff))) begin
               right_col_in   = pixel_col;
               right_valid_in = 1'b1;
            end
         end
         if (in_stop_band) begin
            if ((pixel_col == STOP_COL_L) &&
                (!left_stop_valid_ff || (pixel_row > left_stop_row_ff))) begin
               left_stop_row_in   = pixel_row;
               left_stop_valid_in = 1'b1;
            end
            if ((pixel_col == STOP_COL_R) &&
                (!right_stop_valid_ff || (pixel_row > right_stop_row_ff))) begin
               right_stop_row_in   = pixel_row;
               right_stop_valid_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_col_ff         <= '0;
         right_col_ff        <= '0;
         right_valid_ff      <= 1'b0;
         left_stop_row_ff    <= '0;
         left_stop_valid_ff  <= 1'b0;
         right_stop_row_ff   <= '0;
         right_stop_valid_ff <= 1'b0;
         stable_ff           <= '0;
         held_ff             <= '0;
      end else begin
         left_col_ff         <= left_col_in;
         right_col_ff        <= right_col_in;
         right_valid_ff      <= right_valid_in;
         left_stop_row_ff    <= left_stop_row_in;
         left_stop_valid_ff  <= left_stop_valid_in;
         right_stop_row_ff   <= right_stop_row_in;
         right_stop_valid_ff <= right_stop_valid_in;
         stable_ff           <= stable_in;
         held_ff             <= held_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/lsd_back.sv =====
// ----------------------------------------------------------------------------
// lsd_back
// Takes end-of-frame jobs from the queue, runs a one-bit-per-cycle restoring
// divider for the Q5.11 lateral error, saturates it and holds the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module lsd_back (
   input  logic                               clock,
   input  logic                               reset,
   input  lsd_pkg::qstat_type                 qstat,
   input  lsd_pkg::job_type                   job,
   output logic                               pop,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic signed [lsd_pkg::ERR_W-1:0]   lateral_error,
   output logic                               lane_quality,
   output logic signed [lsd_pkg::STOP_W-1:0]  stop_distance
);

   localparam int MAG_W  = lsd_pkg::MAG_W;
   localparam int ERR_W  = lsd_pkg::ERR_W;
   localparam int ROAD_W = lsd_pkg::ROAD_W;
   localparam int NUM_W  = lsd_pkg::NUM_W;
   localparam int STEP_W = $clog2(MAG_W);
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAG_W - 1);
   localparam logic [MAG_W-1:0]  POS_LIM   = MAG_W'(lsd_pkg::ERR_MAX);
   localparam logic [MAG_W-1:0]  NEG_LIM   = MAG_W'(lsd_pkg::ERR_MAX + 1);

   lsd_pkg::back_state_type state_ff, state_in;

   logic [MAG_W-1:0]  acc_ff, acc_in;
   logic [ROAD_W-1:0] rem_ff, rem_in;
   logic [ROAD_W-1:0] div_ff, div_in;
   logic              neg_ff, neg_in;
   logic              found_ff, found_in;
   logic [lsd_pkg::STOP_W-1:0] stop_ff, stop_in;
   logic [STEP_W-1:0] count_ff, count_in;

   logic              out_valid_ff, out_valid_in;
   logic [ERR_W-1:0]  err_ff, err_in;
   logic              qual_ff, qual_in;
   logic [lsd_pkg::STOP_W-1:0] stop_out_ff, stop_out_in;

   logic step, load;
   logic [NUM_W-1:0]  num_mag;
   logic [ROAD_W:0]   trial;
   logic              trial_ge;
   logic [ERR_W-1:0]  mag_low, err_sat;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lsd_pkg::BK_IDLE: begin
            if (!qstat.empty) begin
               state_in = lsd_pkg::BK_DIVIDE;
            end
         end
         lsd_pkg::BK_DIVIDE: begin
            if (count_ff == STEP_LAST) begin
               state_in = lsd_pkg::BK_FINISH;
            end
         end
         lsd_pkg::BK_FINISH: begin
            if (!out_valid_ff || out_ready) begin
               state_in = lsd_pkg::BK_IDLE;
            end
         end
         default: state_in = lsd_pkg::BK_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      pop  = 1'b0;
      step = 1'b0;
      load = 1'b0;
      unique case (state_ff)
         lsd_pkg::BK_IDLE:   pop  = !qstat.empty;
         lsd_pkg::BK_DIVIDE: step = 1'b1;
         lsd_pkg::BK_FINISH: load = !out_valid_ff || out_ready;
         default: ;
      endcase
   end

   // Divider datapath and saturation.
   always_comb begin
      num_mag  = job.num[NUM_W-1] ? (~job.num + 1'b1) : job.num;
      trial    = {rem_ff, acc_ff[MAG_W-1]};
      trial_ge = (trial >= {1'b0, div_ff});

      mag_low = acc_ff[ERR_W-1:0];
      if (neg_ff) begin
         err_sat = (acc_ff > NEG_LIM) ? {1'b1, {(ERR_W-1){1'b0}}} : (~mag_low + 1'b1);
      end else begin
         err_sat = (acc_ff > POS_LIM) ? {1'b0, {(ERR_W-1){1'b1}}} : mag_low;
      end

      acc_in   = acc_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      neg_in   = neg_ff;
      found_in = found_ff;
      stop_in  = stop_ff;
      count_in = count_ff;
      if (pop) begin
         acc_in   = {num_mag[NUM_W-2:0], {lsd_pkg::FRAC_BITS{1'b0}}};
         rem_in   = '0;
         div_in   = job.divisor;
         neg_in   = job.num[NUM_W-1];
         found_in = job.found;
         stop_in  = job.stop_distance;
         count_in = '0;
      end else if (step) begin
         // Remainder stays below the divisor, so it fits in the divisor width.
         rem_in   = trial_ge ? ROAD_W'(trial - {1'b0, div_ff}) : trial[ROAD_W-1:0];
         acc_in   = {acc_ff[MAG_W-2:0], trial_ge};
         count_in = count_ff + 1'b1;
      end

      out_valid_in = out_valid_ff;
      err_in       = err_ff;
      qual_in      = qual_ff;
      stop_out_in  = stop_out_ff;
      if (load) begin
         out_valid_in = 1'b1;
         err_in       = err_sat;
         qual_in      = found_ff;
         stop_out_in  = stop_ff;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lsd_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      neg_ff      <= neg_in;
      found_ff    <= found_in;
      stop_ff     <= stop_in;
      count_ff    <= count_in;
      err_ff      <= err_in;
      qual_ff     <= qual_in;
      stop_out_ff <= stop_out_in;
   end

   assign out_valid     = out_valid_ff;
   assign lateral_error = $signed(err_ff);
   assign lane_quality  = qual_ff;
   assign stop_distance = $signed(stop_out_ff);

endmodule

`default_nettype wire

// ===== design/lane_edge_stopline_detector.sv =====
// ----------------------------------------------------------------------------
// lane_edge_stopline_detector
// Streams edge-image pixels, tracks lane edges and stopline rows, and on each
// end-of-frame word returns the lateral error, lane quality and stop distance.
//
//   Channel  Direction  Word contents
//   req_     in         pixel or end-of-frame word, kind in tuser
//   rsp_     out        one result word per end-of-frame word
//   csr_     in         register writes, no read-back
//
// Pixel words are taken one per clock and finish in that cycle.
// An end-of-frame word is queued; the back end pops it and runs it through
// the one-bit-per-cycle restoring divider before it loads the result word.
// Pixels keep flowing while the back end divides; an end-of-frame word
// waits only when the two-entry job queue is full.
// Reset is synchronous; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lane_edge_stopline_detector #(
   parameter int IMAGE_WIDTH = lsd_pkg::IMAGE_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_tvalid,
   output logic                               req_tready,
   // pixel_col[9:0], pixel_row[19:10], pixel_value[27:20], in_left_lane[28]
   input  logic [lsd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // action[0]
   input  logic                               req_tuser,

   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // lateral_error[15:0], lane_quality[16], stop_distance[23:17]
   output logic [lsd_pkg::RSP_DATA_W-1:0]     rsp_tdata,

   input  logic                               csr_we,
   input  logic [lsd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lsd_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   lsd_pkg::cfg_type   cfg_ff, cfg_in;
   lsd_pkg::job_type   push_job, pop_job;
   lsd_pkg::qstat_type q_stat;
   logic q_push, q_pop;

   logic signed [lsd_pkg::ERR_W-1:0]  rsp_error;
   logic                              rsp_quality;
   logic signed [lsd_pkg::STOP_W-1:0] rsp_stop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (lsd_pkg::csr_index_type'(csr_index))
            lsd_pkg::CSR_CONTROL_ROW: cfg_in.control_row = csr_wdata[lsd_pkg::ROW_W-1:0];
            lsd_pkg::CSR_STOP_ROW:    cfg_in.stop_row    = csr_wdata[lsd_pkg::ROW_W-1:0];
            lsd_pkg::CSR_ROAD_WIDTH:  cfg_in.road_width  = csr_wdata[lsd_pkg::ROAD_W-1:0];
            lsd_pkg::CSR_ROAD_OFFSET: cfg_in.road_offset = csr_wdata[lsd_pkg::OFFSET_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.control_row <= lsd_pkg::CONTROL_ROW_RESET;
         cfg_ff.stop_row    <= lsd_pkg::STOP_ROW_RESET;
         cfg_ff.road_width  <= lsd_pkg::ROAD_WIDTH_RESET;
         cfg_ff.road_offset <= lsd_pkg::ROAD_OFFSET_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lsd_front #(
      .IMAGE_WIDTH (IMAGE_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .action       (req_tuser),
      .pixel_col    (req_tdata[9:0]),
      .pixel_row    (req_tdata[19:10]),
      .pixel_value  (req_tdata[27:20]),
      .in_left_lane (req_tdata[28]),
      .qstat        (q_stat),
      .push         (q_push),
      .job          (push_job)
   );

   lsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_job),
      .pop       (q_pop),
      .pop_data  (pop_job),
      .qstat     (q_stat)
   );

   lsd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .qstat         (q_stat),
      .job           (pop_job),
      .pop           (q_pop),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .lateral_error (rsp_error),
      .lane_quality  (rsp_quality),
      .stop_distance (rsp_stop)
   );

   assign rsp_tdata = {rsp_stop, rsp_quality, rsp_error};

   `ASSERT_IMPLIES(a_queue_no_overflow, clock, reset, q_push, !q_stat.full, "job pushed into a full queue")
   `ASSERT_IMPLIES(a_queue_no_underflow, clock, reset, q_pop, !q_stat.empty, "job popped from an empty queue")
   `ASSERT_NEXT(a_queue_holds_job, clock, reset, q_push && !q_pop, !q_stat.empty, "pushed job not held")
   `ASSERT_IMPLIES(a_no_edge_zero_error, clock, reset, rsp_tvalid && !rsp_quality, rsp_error == '0, "nonzero error without a lane edge")
   `ASSERT_IMPLIES(a_stop_in_range, clock, reset, rsp_tvalid, (rsp_stop == -7'sd1) || ((rsp_stop >= 7'sd10) && (rsp_stop <= 7'sd60)), "stop distance out of range")

endmodule

`default_nettype wire
